@@ rtl/dss_pkg.sv @@
package dss_pkg;

  localparam int DELIM_MAX_DEF = 8;

  localparam int CHAR_W = 8;
  localparam int TOKN_W = 16;
  localparam int DBYTES_W = 64;
  localparam int DLEN_W = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'd1;

  localparam logic [DBYTES_W-1:0] DELIM_BYTES_RST = '0;
  localparam logic [DLEN_W-1:0] DELIM_LENGTH_RST = 4'd1;

  typedef struct packed {
    logic go_res;
    logic done_nores;
    logic fin;
    logic [CHAR_W-1:0] char_out;
    logic token_end;
    logic [TOKN_W-1:0] token_number;
  } dss_push_t;

endpackage

@@ rtl/dss_if.sv @@
interface dss_in_if import dss_pkg::*; ();
  logic valid;
  logic ready;
  logic [CHAR_W-1:0] char_in;
  logic byte_present;
  logic end_of_string;

  modport source(output valid, char_in, byte_present, end_of_string, input ready);
  modport sink(input valid, char_in, byte_present, end_of_string, output ready);
endinterface

interface dss_out_if import dss_pkg::*; ();
  logic valid;
  logic ready;
  logic [CHAR_W-1:0] char_out;
  logic token_end;
  logic [TOKN_W-1:0] token_number;
  logic last_of_run;

  modport source(output valid, char_out, token_end, token_number, last_of_run, input ready);
  modport sink(input valid, char_out, token_end, token_number, last_of_run, output ready);
endinterface

interface dss_cfg_if import dss_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/delimiter_stream_splitter.sv @@
// Channel   Direction  Payload
// in_ch     sink       char_in, byte_present, end_of_string
// out_ch    source     char_out, token_end, token_number, last_of_run
// cfg       sink       index, data (0: delimiter bytes, 1: delimiter length)
//
// An item yields one result per cycle while the holding stage has space; it ends on a step
// with no result when it yields none or its last result is a released byte. Items that yield
// no result or only a token end are taken one per cycle, the latter while there is space.
// Accepted items pass the current-item registers; results pass the holding and output stages.
// Synchronous reset empties the window and clears the counters; cfg is always ready.
// A stall on out_ch fills the holding stage and then drops in_ch.ready.
module delimiter_stream_splitter import dss_pkg::*; #(
  parameter int DELIM_MAX = DELIM_MAX_DEF
) (
  input logic        clk,
  input logic        rst,
  dss_in_if.sink     in_ch,
  dss_out_if.source  out_ch,
  dss_cfg_if.sink    cfg
);

  localparam int CW = $clog2(DELIM_MAX + 1);

  logic [DBYTES_W-1:0] delim_bytes;
  logic [DLEN_W-1:0]   delim_len;
  logic [CW-1:0]       len_eff;

  logic              cur_valid;
  logic              cur_pb;
  logic              cur_chk;
  logic              cur_eos;
  logic [CHAR_W-1:0] cur_char;

  logic [CW-1:0]     cnt;
  logic              open;
  logic [TOKN_W-1:0] ctr;

  logic [CHAR_W-1:0]    eff [DELIM_MAX];
  logic [DELIM_MAX-1:0] match;

  logic          full;
  logic          app_any;
  logic [CW-1:0] cnt_a;
  logic          chk_a;
  logic          pref;

  logic              res;
  logic              res_end;
  logic              done;
  logic              shift;
  logic [CW-1:0]     cnt_next;
  logic              open_next;
  logic [TOKN_W-1:0] ctr_next;
  logic              chk_next;
  logic              pb_next;
  logic              eos_next;

  logic      space;
  logic      eng_go;
  dss_push_t push;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delim_bytes <= DELIM_BYTES_RST;
      delim_len <= DELIM_LENGTH_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DELIM_BYTES: delim_bytes <= cfg.data;
        REG_DELIM_LENGTH: delim_len <= cfg.data[DLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (delim_len == '0) begin
      len_eff = CW'(1);
    end else if (delim_len > DLEN_W'(DELIM_MAX)) begin
      len_eff = CW'(DELIM_MAX);
    end else begin
      len_eff = delim_len[CW-1:0];
    end
  end

  assign full = (cnt == CW'(DELIM_MAX));
  assign app_any = cur_pb && !full;
  assign cnt_a = cnt + CW'(app_any);
  assign chk_a = cur_chk || app_any;

  genvar gi;
  generate
    for (gi = 0; gi < DELIM_MAX; gi++) begin : g_cell
      logic [CHAR_W-1:0] right;
      if (gi == DELIM_MAX - 1) begin : g_end
        assign right = cur_char;
      end else begin : g_mid
        assign right = eff[gi+1];
      end
      dss_cell u_cell (
        .clk(clk),
        .en(eng_go),
        .app(app_any && (cnt == CW'(gi))),
        .shift(shift),
        .char_in(cur_char),
        .right(right),
        .delim(delim_bytes[CHAR_W*gi +: CHAR_W]),
        .eff(eff[gi]),
        .match(match[gi])
      );
    end
  endgenerate

  always_comb begin
    pref = (cnt_a <= len_eff);
    for (int i = 0; i < DELIM_MAX; i++) begin
      if ((CW'(i) < cnt_a) && !match[i]) begin
        pref = 1'b0;
      end
    end
  end

  always_comb begin
    res = 1'b0;
    res_end = 1'b0;
    done = 1'b0;
    shift = 1'b0;
    cnt_next = cnt;
    open_next = open;
    ctr_next = ctr;
    chk_next = cur_chk;
    pb_next = cur_pb;
    eos_next = cur_eos;
    if (cur_pb && full) begin
      // The oldest byte leaves to make room for the new one.
      res = 1'b1;
      shift = 1'b1;
      pb_next = 1'b0;
      chk_next = 1'b1;
      open_next = 1'b1;
    end else if (chk_a && (cnt_a != '0) && !pref) begin
      res = 1'b1;
      shift = 1'b1;
      cnt_next = cnt_a - CW'(1);
      pb_next = 1'b0;
      chk_next = 1'b1;
      open_next = 1'b1;
    end else if (chk_a && (cnt_a == len_eff)) begin
      res = 1'b1;
      res_end = 1'b1;
      done = 1'b1;
      cnt_next = '0;
      open_next = 1'b0;
      pb_next = 1'b0;
      chk_next = 1'b0;
      eos_next = 1'b0;
      if (cur_eos) begin
        ctr_next = '0;
      end else if (ctr != '1) begin
        ctr_next = ctr + TOKN_W'(1);
      end
    end else begin
      pb_next = 1'b0;
      chk_next = 1'b0;
      cnt_next = cnt_a;
      if (!cur_eos) begin
        done = 1'b1;
      end else if (cnt_a != '0) begin
        res = 1'b1;
        shift = 1'b1;
        cnt_next = cnt_a - CW'(1);
        open_next = 1'b1;
      end else begin
        // End of string with an empty window closes an open token.
        done = 1'b1;
        res = open;
        res_end = 1'b1;
        open_next = 1'b0;
        ctr_next = '0;
        eos_next = 1'b0;
      end
    end
  end

  assign eng_go = cur_valid && (!res || space);
  assign in_ch.ready = !cur_valid || (eng_go && done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_pb <= 1'b0;
      cur_chk <= 1'b0;
      cur_eos <= 1'b0;
      cnt <= '0;
      open <= 1'b0;
      ctr <= '0;
    end else begin
      if (eng_go) begin
        cnt <= cnt_next;
        open <= open_next;
        ctr <= ctr_next;
      end
      if (in_ch.valid && in_ch.ready) begin
        cur_valid <= 1'b1;
        cur_pb <= in_ch.byte_present;
        cur_chk <= 1'b0;
        cur_eos <= in_ch.end_of_string;
      end else if (eng_go) begin
        cur_valid <= !done;
        cur_pb <= pb_next;
        cur_chk <= chk_next;
        cur_eos <= eos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cur_char <= in_ch.char_in;
    end
  end

  always_comb begin
    push.go_res = eng_go && res;
    push.done_nores = eng_go && done && !res;
    push.fin = done;
    push.char_out = res_end ? '0 : eff[0];
    push.token_end = res_end;
    push.token_number = ctr;
  end

  dss_outq u_outq (
    .clk(clk),
    .rst(rst),
    .push(push),
    .space(space),
    .out_ch(out_ch)
  );

endmodule

@@ rtl/dss_cell.sv @@
module dss_cell import dss_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              app,
  input  logic              shift,
  input  logic [CHAR_W-1:0] char_in,
  input  logic [CHAR_W-1:0] right,
  input  logic [CHAR_W-1:0] delim,
  output logic [CHAR_W-1:0] eff,
  output logic              match
);

  logic [CHAR_W-1:0] held;

  // A new byte that lands in this cell is seen by the compare at once.
  assign eff = app ? char_in : held;
  assign match = (eff == delim);

  always_ff @(posedge clk) begin
    if (en) begin
      held <= shift ? right : eff;
    end
  end

endmodule

@@ rtl/dss_outq.sv @@
module dss_outq import dss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dss_push_t push,
  output logic      space,
  dss_out_if.source out_ch
);

  logic              hold_valid;
  logic              hold_fin;
  logic [CHAR_W-1:0] hold_char;
  logic              hold_end;
  logic [TOKN_W-1:0] hold_num;

  logic              out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              out_end;
  logic [TOKN_W-1:0] out_num;
  logic              out_last;

  logic out_free;
  logic hold_move;

  // The newest result waits here until it is known whether more follow.
  assign out_free = !out_valid || out_ch.ready;
  assign space = !hold_valid || out_free;
  assign hold_move = hold_valid && out_free && (hold_fin || push.go_res);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      hold_fin <= 1'b0;
    end else if (push.go_res) begin
      hold_valid <= 1'b1;
      hold_fin <= push.fin;
    end else if (hold_move) begin
      hold_valid <= 1'b0;
    end else if (push.done_nores && hold_valid) begin
      hold_fin <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push.go_res) begin
      hold_char <= push.char_out;
      hold_end <= push.token_end;
      hold_num <= push.token_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_move) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      out_char <= hold_char;
      out_end <= hold_end;
      out_num <= hold_num;
      out_last <= hold_fin;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.char_out = out_char;
  assign out_ch.token_end = out_end;
  assign out_ch.token_number = out_num;
  assign out_ch.last_of_run = out_last;

endmodule

@@ rtl/dss_checker.sv @@
module dss_checker import dss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_out,
  input logic              token_end,
  input logic [TOKN_W-1:0] token_number,
  input logic              last_of_run
);

  logic              seen;
  logic              prev_end;
  logic [TOKN_W-1:0] prev_num;
  logic              out_acc;

  assign out_acc = out_valid && out_ready;

  // Remembers the previous item on out_ch while its run is still going.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_acc) begin
      seen <= !last_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_end <= token_end;
      prev_num <= token_number;
    end
  end

  a_same_token: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen && !prev_end |-> token_number == prev_num)
    else $error("token number changed inside a token");

  a_next_token: assert property (@(posedge clk) disable iff (rst)
    out_acc && seen && prev_end |->
      (token_number == TOKN_W'(prev_num + TOKN_W'(1))) ||
      ((prev_num == '1) && (token_number == prev_num)))
    else $error("token number did not advance after a cut");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_end |-> char_out == '0)
    else $error("token end carries a byte");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(token_end) &&
      $stable(token_number) && $stable(last_of_run))
    else $error("stalled output item changed");

endmodule

bind delimiter_stream_splitter dss_checker u_dss_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .char_out(out_ch.char_out),
  .token_end(out_ch.token_end),
  .token_number(out_ch.token_number),
  .last_of_run(out_ch.last_of_run)
);

@@ dv/tb_delimiter_stream_splitter.sv @@
`timescale 1ns / 100ps

typedef struct packed {
  logic [dss_pkg::CHAR_W-1:0] char_out;
  logic token_end;
  logic [dss_pkg::TOKN_W-1:0] token_number;
  logic last_of_run;
} split_result_t;

class token_split_scoreboard;
  logic [dss_pkg::DBYTES_W-1:0] delim_bytes;
  logic [dss_pkg::DLEN_W-1:0] delim_len;
  logic [dss_pkg::CHAR_W-1:0] window [dss_pkg::DELIM_MAX_DEF];
  int unsigned fill;
  logic [dss_pkg::TOKN_W-1:0] token_idx;
  bit token_open;
  split_result_t token_results_q[$];
  int unsigned errors;

  function new();
    delim_bytes = dss_pkg::DELIM_BYTES_RST;
    delim_len = dss_pkg::DELIM_LENGTH_RST;
    fill = 0;
    token_idx = '0;
    token_open = 1'b0;
    errors = 0;
    foreach (window[i]) window[i] = '0;
  endfunction

  function void write_reg(logic [dss_pkg::CFG_IDX_W-1:0] idx,
                          logic [dss_pkg::CFG_DATA_W-1:0] data);
    if (idx == dss_pkg::REG_DELIM_BYTES) begin
      delim_bytes = data;
    end else if (idx == dss_pkg::REG_DELIM_LENGTH) begin
      delim_len = data[dss_pkg::DLEN_W-1:0];
    end
  endfunction

  function int unsigned match_len();
    int unsigned v;
    v = delim_len;
    if (v < 1) v = 1;
    if (v > dss_pkg::DELIM_MAX_DEF) v = dss_pkg::DELIM_MAX_DEF;
    return v;
  endfunction

  function logic [dss_pkg::CHAR_W-1:0] delim_char(int unsigned i);
    return delim_bytes[8*(i%8) +: 8];
  endfunction

  function bit window_is_prefix(int unsigned len);
    int unsigned i;
    if (fill > len) return 1'b0;
    for (i = 0; i < fill; i++) begin
      if (window[i] != delim_char(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void push_result(logic [dss_pkg::CHAR_W-1:0] ch, logic tend);
    split_result_t r;
    r.char_out = tend ? '0 : ch;
    r.token_end = tend;
    r.token_number = token_idx;
    r.last_of_run = 1'b0;
    token_results_q.push_back(r);
  endfunction

  function void release_oldest();
    int unsigned i;
    if (fill == 0) return;
    push_result(window[0], 1'b0);
    token_open = 1'b1;
    for (i = 1; i < fill; i++) window[i-1] = window[i];
    fill--;
  endfunction

  function void split_item(logic [dss_pkg::CHAR_W-1:0] c, logic present, logic eos);
    int unsigned len;
    int unsigned prior_size;
    len = match_len();
    prior_size = token_results_q.size();
    if (present) begin
      if (fill >= dss_pkg::DELIM_MAX_DEF) release_oldest();
      window[fill] = c;
      fill++;
      while (fill > 0 && !window_is_prefix(len)) release_oldest();
      if (fill == len) begin
        push_result('0, 1'b1);
        if (token_idx != '1) token_idx++;
        fill = 0;
        token_open = 1'b0;
      end
    end
    if (eos) begin
      while (fill > 0) release_oldest();
      if (token_open) push_result('0, 1'b1);
      token_idx = '0;
      token_open = 1'b0;
    end
    if (token_results_q.size() > prior_size) begin
      token_results_q[token_results_q.size()-1].last_of_run = 1'b1;
    end
  endfunction

  function void compare_result(split_result_t got);
    split_result_t want;
    if (token_results_q.size() == 0) begin
      $error("unexpected result: char_out %0d token_end %0d token_number %0d last_of_run %0d",
             got.char_out, got.token_end, got.token_number, got.last_of_run);
      errors++;
      return;
    end
    want = token_results_q.pop_front();
    if (got.token_end != want.token_end) begin
      $error("token_end: expected %0d, actual %0d", want.token_end, got.token_end);
      errors++;
    end
    if (!want.token_end && got.char_out != want.char_out) begin
      $error("char_out: expected %0d, actual %0d", want.char_out, got.char_out);
      errors++;
    end
    if (got.token_number != want.token_number) begin
      $error("token_number: expected %0d, actual %0d", want.token_number, got.token_number);
      errors++;
    end
    if (got.last_of_run != want.last_of_run) begin
      $error("last_of_run: expected %0d, actual %0d", want.last_of_run, got.last_of_run);
      errors++;
    end
  endfunction
endclass

module tb_delimiter_stream_splitter;
  import dss_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int RANDOM_SEGMENTS = 12;
  localparam int SEGMENT_ITEMS = 26;
  localparam logic [DLEN_W-1:0] SEG_LENS [RANDOM_SEGMENTS] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd4, 4'd9, 4'd5, 4'd6, 4'd7, 4'd1};

  logic clk;
  logic rst;
  int src_idle_pct = 38;
  int snk_idle_pct = 75;
  int unsigned cycle_count;
  int unsigned items_sent = 0;
  token_split_scoreboard sb;

  dss_in_if in_ch ();
  dss_out_if out_ch ();
  dss_cfg_if cfg_ch ();

  delimiter_stream_splitter uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    split_result_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        sb.split_item(in_ch.char_in, in_ch.byte_present, in_ch.end_of_string);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.char_out = out_ch.char_out;
        got.token_end = out_ch.token_end;
        got.token_number = out_ch.token_number;
        got.last_of_run = out_ch.last_of_run;
        sb.compare_result(got);
      end
    end
  end

  task automatic send_item(input logic [CHAR_W-1:0] c, input logic present, input logic eos);
    if (present || eos) items_sent++;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_in <= c;
    in_ch.byte_present <= present;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.token_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delimiter(input logic [DBYTES_W-1:0] bytes, input logic [DLEN_W-1:0] len);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_DELIM_BYTES;
    cfg_ch.data <= bytes;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_DELIM_LENGTH;
    cfg_ch.data <= {{(CFG_DATA_W-DLEN_W){1'b0}}, len};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 50) return sb.delim_char($urandom_range(7));
    if (k < 60) return 8'h00;
    if (k < 70) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [DBYTES_W-1:0] random_delimiter(int unsigned seg);
    logic [DBYTES_W-1:0] d;
    logic [CHAR_W-1:0] alpha [3];
    int unsigned i;
    if (seg == 1) return '1;
    if (seg == 2) return '0;
    for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
    for (i = 0; i < 8; i++) d[8*i +: 8] = alpha[$urandom_range(2)];
    return d;
  endfunction

  // A string is a mix of whole delimiters, partial delimiters and plain bytes.
  // Most strings are closed, some run on into the next one.
  task automatic send_string();
    logic [CHAR_W-1:0] q[$];
    int unsigned len, k, n, ending;
    int j;
    len = sb.match_len();
    repeat ($urandom_range(6)) begin
      k = $urandom_range(99);
      if (k < 35) begin
        for (j = 0; j < len; j++) q.push_back(sb.delim_char(j));
      end else if (k < 55) begin
        n = $urandom_range(len - 1);
        for (j = 0; j < n; j++) q.push_back(sb.delim_char(j));
      end else begin
        repeat ($urandom_range(4, 1)) q.push_back(pick_char());
      end
    end
    ending = $urandom_range(99);
    for (j = 0; j < q.size(); j++) begin
      if ($urandom_range(99) < 5) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(q[j], 1'b1, (ending < 45) && (j == q.size() - 1));
    end
    if (ending < 85 && (ending >= 45 || q.size() == 0)) send_item(pick_char(), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned seg, target, drain;
    sb = new();
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.char_in <= '0;
    in_ch.byte_present <= 1'b0;
    in_ch.end_of_string <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_DELIM_BYTES;
    cfg_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The zero byte as a one-byte delimiter, with a length of 0 that acts as 1.
    set_delimiter(64'h0, 4'd0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    // A length of 15 acts as 8; then the delimiter changes while seven bytes wait in the window.
    set_delimiter('1, 4'd15);
    repeat (15) send_item(8'hFF, 1'b1, 1'b0);
    wait_idle();
    set_delimiter(64'h01FF, 4'd2);
    send_item(8'h01, 1'b1, 1'b1);
    wait_idle();

    for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      src_idle_pct = seg < 4 ? 38 : (seg < 8 ? 75 : 0);
      snk_idle_pct = seg < 4 ? 75 : (seg < 8 ? 38 : 0);
      wait_idle();
      set_delimiter(random_delimiter(seg), SEG_LENS[seg]);
      target = items_sent + SEGMENT_ITEMS;
      while (items_sent < target) send_string();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (sb.token_results_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.token_results_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.token_results_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
